FILE: design/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// No dependencies; taken in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/gss_pkg.sv
// Types and constants of the gear shift sequencer.
// No dependencies; used by gss_core and gear_shift_sequencer.
package gss_pkg;

  // Event kinds carried on the input tuser field
  typedef enum logic [2:0] {
    KindTick     = 3'd0,
    KindGear     = 3'd1,
    KindUp       = 3'd2,
    KindDown     = 3'd3,
    KindNeutral  = 3'd4,
    KindSearch   = 3'd5,
    KindLaunch   = 3'd6
  } kind_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CfgShiftCut   = 3'd0,
    CfgUpPulse    = 3'd1,
    CfgDownPulse  = 3'd2,
    CfgSettle     = 3'd3,
    CfgAdjust     = 3'd4,
    CfgAttempts   = 3'd5,
    CfgLaunch     = 3'd6
  } cfg_idx_e;

  // Sequencer phases, one-hot
  typedef enum logic [10:0] {
    PhIdle        = 11'b000_0000_0001,
    PhUpCut       = 11'b000_0000_0010,
    PhUpRun       = 11'b000_0000_0100,
    PhDownRun     = 11'b000_0000_1000,
    PhNsUpPulse   = 11'b000_0001_0000,
    PhNsUpSettle  = 11'b000_0010_0000,
    PhNsDnPulse   = 11'b000_0100_0000,
    PhNsDnSettle  = 11'b000_1000_0000,
    PhNrPulse     = 11'b001_0000_0000,
    PhNrSettle    = 11'b010_0000_0000,
    PhLaunch      = 11'b100_0000_0000
  } phase_e;

  // Gear codes
  localparam logic [3:0] GearFirst   = 4'd1;
  localparam logic [3:0] GearSecond  = 4'd2;
  localparam logic [3:0] GearFifth   = 4'd5;
  localparam logic [3:0] GearUnknown = 4'd11;

  // Drive line bit positions
  localparam int LineCut    = 0;
  localparam int LineUp     = 1;
  localparam int LineDown   = 2;
  localparam int LineLaunch = 3;

  localparam int CfgWidth = 16;
  localparam int TryWidth = 16;

  // One result item
  typedef struct packed {
    logic [TryWidth-1:0] down_try_now;
    logic [TryWidth-1:0] up_try_now;
    logic                accepted;
    logic                busy_now;
    logic                launch_on;
    logic                down_solenoid_on;
    logic                up_solenoid_on;
    logic                shift_cut_on;
  } res_t;

endpackage

FILE: design/gss_core.sv
// Sequencer state, configuration registers and next-state logic.
// Depends on gss_pkg.
module gss_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  logic [2:0]                kind_i,
  input  logic [3:0]                gear_i,
  input  logic                      cfg_we_i,
  input  logic [2:0]                cfg_idx_i,
  input  logic [gss_pkg::CfgWidth-1:0] cfg_data_i,
  output gss_pkg::res_t             res_o
);
  import gss_pkg::*;

  // Configuration
  logic [15:0] cut_q, up_pulse_q, dn_pulse_q, settle_q, launch_q;
  logic [9:0]  adj_q;
  logic [4:0]  limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_q      <= 16'd1000;
      up_pulse_q <= 16'd1000;
      dn_pulse_q <= 16'd1000;
      settle_q   <= 16'd10000;
      adj_q      <= 10'd50;
      limit_q    <= 5'd10;
      launch_q   <= 16'd500;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgShiftCut:  cut_q      <= cfg_data_i;
        CfgUpPulse:   up_pulse_q <= cfg_data_i;
        CfgDownPulse: dn_pulse_q <= cfg_data_i;
        CfgSettle:    settle_q   <= cfg_data_i;
        CfgAdjust:    adj_q      <= cfg_data_i[9:0];
        CfgAttempts:  limit_q    <= cfg_data_i[4:0];
        CfgLaunch:    launch_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state
  logic        busy_q, busy_d;
  phase_e      phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d;
  logic [3:0]  gear_q, gear_d;
  logic [1:0]  prev_q, prev_d;
  logic [4:0]  att_q, att_d;
  logic [15:0] up_q, up_d, dn_q, dn_d;
  logic [3:0]  lines_q, lines_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= PhIdle;
      cnt_q   <= '0;
      gear_q  <= GearUnknown;
      prev_q  <= '0;
      att_q   <= '0;
      up_q    <= 16'd500;
      dn_q    <= 16'd500;
      lines_q <= '0;
    end else if (fire_i) begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      gear_q  <= gear_d;
      prev_q  <= prev_d;
      att_q   <= att_d;
      up_q    <= up_d;
      dn_q    <= dn_d;
      lines_q <= lines_d;
    end
  end

  // Saturating pulse length adjustments
  logic [16:0] up_sum, dn_sum;
  logic [15:0] adj_ext, up_plus, up_minus, dn_plus, dn_minus;

  always_comb begin
    adj_ext  = {6'd0, adj_q};
    up_sum   = {1'b0, up_q} + {1'b0, adj_ext};
    dn_sum   = {1'b0, dn_q} + {1'b0, adj_ext};
    up_plus  = up_sum[16] ? 16'hFFFF : up_sum[15:0];
    dn_plus  = dn_sum[16] ? 16'hFFFF : dn_sum[15:0];
    up_minus = (up_q > adj_ext) ? up_q - adj_ext : 16'd0;
    dn_minus = (dn_q > adj_ext) ? dn_q - adj_ext : 16'd0;
  end

  // One step of the repeated neutral search; a fresh search starts cleared
  logic        fresh;
  logic [1:0]  s_prev, sr_prev;
  logic [4:0]  s_att, sr_att;
  logic        sr_busy;
  phase_e      sr_phase;
  logic [15:0] sr_cnt, sr_up, sr_dn;
  logic [3:0]  sr_lines;

  assign fresh = (kind_i == KindSearch);

  always_comb begin
    s_prev   = fresh ? 2'd0 : prev_q;
    s_att    = fresh ? 5'd0 : att_q;
    sr_prev  = s_prev;
    sr_att   = s_att;
    sr_busy  = 1'b1;
    sr_phase = phase_q;
    sr_cnt   = 16'd0;
    sr_up    = up_q;
    sr_dn    = dn_q;
    sr_lines = lines_q;
    if (gear_q == GearUnknown) begin
      // unknown gear: one plain up pulse ends the search
      sr_lines[LineUp] = 1'b1;
      sr_phase = PhNsUpPulse;
      sr_cnt   = up_q;
    end else begin
      sr_att = s_att + 5'd1;
      if (s_att == limit_q || (gear_q != GearFirst && gear_q != GearSecond)) begin
        sr_busy  = 1'b0;
        sr_phase = PhIdle;
      end else if (gear_q == GearFirst) begin
        if (s_prev == 2'd1) begin
          sr_up  = up_plus;
        end else if (s_prev == 2'd2) begin
          sr_dn  = dn_minus;
        end
        sr_lines[LineUp] = 1'b1;
        sr_phase = PhNrPulse;
        sr_cnt   = (s_prev == 2'd1) ? up_plus : up_q;
        sr_prev  = gear_q[1:0];
      end else begin
        if (s_prev == 2'd1) begin
          sr_up  = up_minus;
        end else if (s_prev == 2'd2) begin
          sr_dn  = dn_plus;
        end
        sr_lines[LineDown] = 1'b1;
        sr_phase = PhNrPulse;
        sr_cnt   = (s_prev == 2'd2) ? dn_plus : dn_q;
        sr_prev  = gear_q[1:0];
      end
    end
  end

  // Next state for one event
  logic request;

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    gear_d  = gear_q;
    prev_d  = prev_q;
    att_d   = att_q;
    up_d    = up_q;
    dn_d    = dn_q;
    lines_d = lines_q;
    request = 1'b0;
    case (kind_i)
      KindTick: begin
        if (busy_q) begin
          if (cnt_q > 16'd1) begin
            cnt_d = cnt_q - 16'd1;
          end else begin
            cnt_d = 16'd0;
            case (phase_q)
              PhUpCut: begin
                lines_d[LineCut] = 1'b0;
                lines_d[LineUp]  = 1'b1;
                phase_d = PhUpRun;
                cnt_d   = up_pulse_q;
              end
              PhUpRun, PhDownRun: begin
                lines_d[LineUp]   = 1'b0;
                lines_d[LineDown] = 1'b0;
                busy_d  = 1'b0;
                phase_d = PhIdle;
              end
              PhNsUpPulse: begin
                lines_d[LineUp] = 1'b0;
                phase_d = PhNsUpSettle;
                cnt_d   = settle_q;
              end
              PhNsUpSettle: begin
                if (gear_q == GearFirst) begin
                  up_d = up_plus;
                end else if (gear_q == GearSecond) begin
                  up_d = up_minus;
                end
                busy_d  = 1'b0;
                phase_d = PhIdle;
              end
              PhNsDnPulse: begin
                lines_d[LineDown] = 1'b0;
                phase_d = PhNsDnSettle;
                cnt_d   = settle_q;
              end
              PhNsDnSettle: begin
                if (gear_q == GearFirst) begin
                  dn_d = dn_minus;
                end else if (gear_q == GearSecond) begin
                  dn_d = dn_plus;
                end
                busy_d  = 1'b0;
                phase_d = PhIdle;
              end
              PhNrPulse: begin
                lines_d[LineUp]   = 1'b0;
                lines_d[LineDown] = 1'b0;
                phase_d = PhNrSettle;
                cnt_d   = settle_q;
              end
              PhNrSettle: begin
                busy_d  = sr_busy;
                phase_d = sr_phase;
                cnt_d   = sr_cnt;
                prev_d  = sr_prev;
                att_d   = sr_att;
                up_d    = sr_up;
                dn_d    = sr_dn;
                lines_d = sr_lines;
              end
              PhLaunch: begin
                lines_d[LineLaunch] = 1'b0;
                busy_d  = 1'b0;
                phase_d = PhIdle;
              end
              default: begin
                lines_d = '0;
                busy_d  = 1'b0;
                phase_d = PhIdle;
              end
            endcase
          end
        end
      end
      KindGear: gear_d = gear_i;
      KindUp: begin
        request = 1'b1;
        if (!busy_q && gear_q != GearFifth) begin
          busy_d  = 1'b1;
          lines_d[LineCut] = 1'b1;
          phase_d = PhUpCut;
          cnt_d   = cut_q;
        end
      end
      KindDown: begin
        request = 1'b1;
        if (!busy_q && gear_q != GearFirst) begin
          busy_d  = 1'b1;
          lines_d[LineDown] = 1'b1;
          phase_d = PhDownRun;
          cnt_d   = dn_pulse_q;
        end
      end
      KindNeutral: begin
        request = 1'b1;
        if (!busy_q) begin
          if (gear_q == GearFirst || gear_q == GearUnknown) begin
            busy_d  = 1'b1;
            lines_d[LineUp] = 1'b1;
            phase_d = PhNsUpPulse;
            cnt_d   = up_q;
          end else if (gear_q == GearSecond) begin
            busy_d  = 1'b1;
            lines_d[LineDown] = 1'b1;
            phase_d = PhNsDnPulse;
            cnt_d   = dn_q;
          end
        end
      end
      KindSearch: begin
        request = 1'b1;
        if (!busy_q) begin
          prev_d = 2'd0;
          att_d  = 5'd0;
          if (gear_q == GearFirst || gear_q == GearSecond || gear_q == GearUnknown) begin
            busy_d  = sr_busy;
            phase_d = sr_phase;
            cnt_d   = sr_cnt;
            prev_d  = sr_prev;
            att_d   = sr_att;
            up_d    = sr_up;
            dn_d    = sr_dn;
            lines_d = sr_lines;
          end
        end
      end
      KindLaunch: begin
        request = 1'b1;
        if (!busy_q) begin
          busy_d  = 1'b1;
          lines_d[LineLaunch] = 1'b1;
          phase_d = PhLaunch;
          cnt_d   = launch_q;
        end
      end
      default: ;
    endcase
  end

  // Result of this event, taken from the next state
  always_comb begin
    res_o.shift_cut_on     = lines_d[LineCut];
    res_o.up_solenoid_on   = lines_d[LineUp];
    res_o.down_solenoid_on = lines_d[LineDown];
    res_o.launch_on        = lines_d[LineLaunch];
    res_o.busy_now         = busy_d;
    res_o.accepted         = request && !busy_q && busy_d;
    res_o.up_try_now       = up_d;
    res_o.down_try_now     = dn_d;
  end

endmodule

FILE: design/gear_shift_sequencer.sv
// Gear shift sequencer: input register, sequencer core, result register.
// A request taken into the input register passes through the sequencer core into the result register.
// Throughput: one request per cycle while the receiver takes results; the result register
// lets a new request enter while a finished result waits to be taken.
// Reset (rst_ni low, asynchronous): lines released, idle, gear unknown, pulse
// lengths 500 ticks, configuration at defaults. Needs gss_pkg and gss_core.
`include "assert_macros.svh"
module gear_shift_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [3:0] gear_value, [7:4] zero
  input  logic [2:0]  s_axis_tuser,  // [2:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] shift_cut_on, [1] up_solenoid_on, [2] down_solenoid_on, [3] launch_on,
  // [4] busy_now, [5] accepted, [21:6] up_try_now, [37:22] down_try_now,
  // [39:38] zero
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [gss_pkg::CfgWidth-1:0] cfg_data_i
);
  import gss_pkg::*;

  logic       in_vld_q;
  logic [2:0] in_kind_q;
  logic [3:0] in_gear_q;
  logic       out_vld_q;
  res_t       out_q;
  res_t       res;
  logic       advance;

  // Input stage moves on when the result register is free or being drained
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind_q <= s_axis_tuser;
      in_gear_q <= s_axis_tdata[3:0];
    end
  end

  gss_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (advance),
    .kind_i     (in_kind_q),
    .gear_i     (in_gear_q),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .res_o      (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_q};

  // Checks
  logic in_stall, out_stall, out_idle, lines_on, acc_fire;

  assign in_stall  = in_vld_q && !s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_idle  = m_axis_tvalid && !out_q.busy_now;
  assign lines_on  = out_q.shift_cut_on || out_q.up_solenoid_on ||
                     out_q.down_solenoid_on || out_q.launch_on;
  assign acc_fire  = advance && res.accepted;

  `ASSERT_NEXT(a_adv_shows, clk_i, rst_ni, advance, m_axis_tvalid, "result missing after advance")
  `ASSERT_IMPL(a_stall_src, clk_i, rst_ni, in_stall, out_stall, "stall without backpressure")
  `ASSERT_IMPL(a_idle_lines, clk_i, rst_ni, out_idle, !lines_on, "line driven while idle")
  `ASSERT_IMPL(a_acc_busy, clk_i, rst_ni, acc_fire, res.busy_now, "accepted without busy")

endmodule

FILE: tb/gear_shift_sequencer_tb.sv
// Self-checking testbench for gear_shift_sequencer: a scoreboard class predicts every
// result from the accepted event stream, and plain tasks drive the event and register ports.
// Depends on gss_pkg and the gear_shift_sequencer RTL.
module gear_shift_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gss_pkg::*;

  // Predicts the actuator outputs and holds the results still due from the block
  class actuator_scoreboard;
    // register copies, reset values
    logic [15:0] cut_len      = 16'd1000;
    logic [15:0] up_run_len   = 16'd1000;
    logic [15:0] down_run_len = 16'd1000;
    logic [15:0] settle_len   = 16'd10000;
    logic [9:0]  adjust_step  = 10'd50;
    logic [4:0]  attempt_cap  = 5'd10;
    logic [15:0] launch_len   = 16'd500;

    // sequencer state
    logic        seq_busy   = 1'b0;
    phase_e      seq_phase  = PhIdle;
    logic [15:0] ticks_left = '0;
    logic [3:0]  gear_seen  = GearUnknown;
    logic [1:0]  prior_gear = '0;
    logic [4:0]  tries_done = '0;
    logic [15:0] up_len     = 16'd500;
    logic [15:0] down_len   = 16'd500;
    logic [3:0]  lines      = '0;

    res_t due_outputs[$];
    int   failures = 0;

    function void set_register(cfg_idx_e idx, logic [15:0] value);
      case (idx)
        CfgShiftCut:  cut_len      = value;
        CfgUpPulse:   up_run_len   = value;
        CfgDownPulse: down_run_len = value;
        CfgSettle:    settle_len   = value;
        CfgAdjust:    adjust_step  = value[9:0];
        CfgAttempts:  attempt_cap  = value[4:0];
        CfgLaunch:    launch_len   = value;
        default: ;
      endcase
    endfunction

    // saturating pulse length arithmetic
    function logic [15:0] grow(logic [15:0] a, logic [9:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {7'b0, b};
      return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function logic [15:0] shrink(logic [15:0] a, logic [9:0] b);
      return (a > {6'b0, b}) ? a - {6'b0, b} : 16'd0;
    endfunction

    function void enter_phase(phase_e p, logic [15:0] n);
      seq_phase  = p;
      ticks_left = n;
    endfunction

    function void end_sequence();
      seq_busy   = 1'b0;
      seq_phase  = PhIdle;
      ticks_left = '0;
    endfunction

    // one neutral pulse from first (or unknown) or second gear
    function bit start_single();
      if (gear_seen == GearFirst || gear_seen == GearUnknown) begin
        seq_busy = 1'b1;
        lines[LineUp] = 1'b1;
        enter_phase(PhNsUpPulse, up_len);
        return 1'b1;
      end
      if (gear_seen == GearSecond) begin
        seq_busy = 1'b1;
        lines[LineDown] = 1'b1;
        enter_phase(PhNsDnPulse, down_len);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // next pulse of a repeated neutral search
    function void search_step();
      bit at_cap;
      if (gear_seen == GearUnknown) begin
        void'(start_single());
        return;
      end
      at_cap = (tries_done == attempt_cap);
      tries_done = tries_done + 5'd1;
      if (at_cap || (gear_seen != GearFirst && gear_seen != GearSecond)) begin
        end_sequence();
        return;
      end
      if (gear_seen == GearFirst) begin
        if ({2'b00, prior_gear} == GearFirst) up_len = grow(up_len, adjust_step);
        else if ({2'b00, prior_gear} == GearSecond) down_len = shrink(down_len, adjust_step);
        lines[LineUp] = 1'b1;
        enter_phase(PhNrPulse, up_len);
      end else begin
        if ({2'b00, prior_gear} == GearFirst) up_len = shrink(up_len, adjust_step);
        else if ({2'b00, prior_gear} == GearSecond) down_len = grow(down_len, adjust_step);
        lines[LineDown] = 1'b1;
        enter_phase(PhNrPulse, down_len);
      end
      prior_gear = gear_seen[1:0];
    endfunction

    function void phase_done();
      case (seq_phase)
        PhUpCut: begin
          lines[LineCut] = 1'b0;
          lines[LineUp]  = 1'b1;
          enter_phase(PhUpRun, up_run_len);
        end
        PhUpRun, PhDownRun: begin
          lines[LineUp]   = 1'b0;
          lines[LineDown] = 1'b0;
          end_sequence();
        end
        PhNsUpPulse: begin
          lines[LineUp] = 1'b0;
          enter_phase(PhNsUpSettle, settle_len);
        end
        PhNsUpSettle: begin
          // still in first: pulse was too short; landed in second: too long
          if (gear_seen == GearFirst) up_len = grow(up_len, adjust_step);
          else if (gear_seen == GearSecond) up_len = shrink(up_len, adjust_step);
          end_sequence();
        end
        PhNsDnPulse: begin
          lines[LineDown] = 1'b0;
          enter_phase(PhNsDnSettle, settle_len);
        end
        PhNsDnSettle: begin
          if (gear_seen == GearFirst) down_len = shrink(down_len, adjust_step);
          else if (gear_seen == GearSecond) down_len = grow(down_len, adjust_step);
          end_sequence();
        end
        PhNrPulse: begin
          lines[LineUp]   = 1'b0;
          lines[LineDown] = 1'b0;
          enter_phase(PhNrSettle, settle_len);
        end
        PhNrSettle: search_step();
        PhLaunch: begin
          lines[LineLaunch] = 1'b0;
          end_sequence();
        end
        default: begin
          lines = '0;
          end_sequence();
        end
      endcase
    endfunction

    // apply one accepted event and queue the result it causes
    function void note_event(logic [2:0] kind, logic [3:0] gear);
      bit   was_busy;
      bit   is_req;
      res_t want;
      was_busy = seq_busy;
      is_req   = (kind >= KindUp) && (kind <= KindLaunch);
      if (kind == KindTick) begin
        if (seq_busy) begin
          if (ticks_left <= 16'd1) begin
            ticks_left = '0;
            phase_done();
          end else begin
            ticks_left = ticks_left - 16'd1;
          end
        end
      end else if (kind == KindGear) begin
        gear_seen = gear;
      end else if (is_req && !seq_busy) begin
        case (kind)
          KindUp: if (gear_seen != GearFifth) begin
            seq_busy = 1'b1;
            lines[LineCut] = 1'b1;
            enter_phase(PhUpCut, cut_len);
          end
          KindDown: if (gear_seen != GearFirst) begin
            seq_busy = 1'b1;
            lines[LineDown] = 1'b1;
            enter_phase(PhDownRun, down_run_len);
          end
          KindNeutral: void'(start_single());
          KindSearch: begin
            prior_gear = '0;
            tries_done = '0;
            if (gear_seen == GearFirst || gear_seen == GearSecond) begin
              seq_busy = 1'b1;
              search_step();
            end else if (gear_seen == GearUnknown) begin
              void'(start_single());
            end
          end
          KindLaunch: begin
            seq_busy = 1'b1;
            lines[LineLaunch] = 1'b1;
            enter_phase(PhLaunch, launch_len);
          end
          default: ;
        endcase
      end
      want.shift_cut_on     = lines[LineCut];
      want.up_solenoid_on   = lines[LineUp];
      want.down_solenoid_on = lines[LineDown];
      want.launch_on        = lines[LineLaunch];
      want.busy_now         = seq_busy;
      want.accepted         = is_req && !was_busy && seq_busy;
      want.up_try_now       = up_len;
      want.down_try_now     = down_len;
      due_outputs.push_back(want);
    endfunction

    function string describe(res_t r);
      return $sformatf("cut=%b up=%b dn=%b launch=%b busy=%b acc=%b up_try=%0d dn_try=%0d",
                       r.shift_cut_on, r.up_solenoid_on, r.down_solenoid_on, r.launch_on,
                       r.busy_now, r.accepted, r.up_try_now, r.down_try_now);
    endfunction

    function void check_output(logic [39:0] word);
      res_t got;
      res_t want;
      got = word[37:0];
      if (due_outputs.size() == 0) begin
        failures++;
        if (failures <= 10) $display("%0t: result with none due: %s", $realtime, describe(got));
        return;
      end
      want = due_outputs.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  localparam logic [2:0]  KindSpare  = 3'd7;   // unused kind, block ignores it
  localparam int unsigned CycleLimit = 400000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic [2:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_idx_i     = '0;
  logic [15:0] cfg_data_i    = '0;

  actuator_scoreboard sb = new;

  int          send_idle_pct = 13;
  int          recv_idle_pct = 80;
  int          items_sent    = 0;
  int unsigned cycle_count   = 0;

  gear_shift_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver stalls at random
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_output(m_axis_tdata);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("gear_shift_sequencer_tb: errors");
      $finish;
    end
  end

  // gears weighted toward the ones that steer the sequences
  function automatic logic [3:0] pick_gear();
    int r;
    r = $urandom_range(9);
    if (r < 2) return GearFirst;
    if (r < 4) return GearSecond;
    if (r == 4) return 4'd0;
    if (r == 5) return GearFifth;
    if (r == 6) return GearUnknown;
    return 4'($urandom_range(15));
  endfunction

  // one request on the event port; entered and left at a falling edge
  task automatic send_item(logic [2:0] kind, logic [3:0] gear);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'b0000, gear};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_event(kind, gear);
    if (kind != KindSpare) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.set_register(idx, value);
    @(negedge clk_i);
  endtask

  task automatic write_config(int cut, int up, int down, int settle, int adjust, int cap,
                              int launch);
    write_reg(CfgShiftCut, 16'(cut));
    write_reg(CfgUpPulse, 16'(up));
    write_reg(CfgDownPulse, 16'(down));
    write_reg(CfgSettle, 16'(settle));
    write_reg(CfgAdjust, 16'(adjust));
    write_reg(CfgAttempts, 16'(cap));
    write_reg(CfgLaunch, 16'(launch));
    cfg_we_i <= 1'b0;
  endtask

  // all results in, then a margin for the pipeline
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.due_outputs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic tick_until_idle(bit mix_gears);
    int guard = 0;
    while (sb.seq_busy && guard < 4000) begin
      if (mix_gears && $urandom_range(7) == 0) send_item(KindGear, pick_gear());
      send_item(KindTick, 4'h0);
      guard++;
    end
  endtask

  // at times a gear report or a spare kind, a request, then a burst of ticks sized from the live countdown
  task automatic random_episode();
    int         run;
    int         r;
    logic [2:0] req;
    r = $urandom_range(9);
    if (r < 3) send_item(KindGear, pick_gear());
    else if (r == 3) send_item(KindSpare, 4'($urandom_range(15)));
    req = 3'($urandom_range(KindLaunch, KindUp));
    send_item(req, 4'($urandom_range(15)));
    if (!sb.seq_busy) run = $urandom_range(2);
    else if ($urandom_range(3) == 0) run = $urandom_range(sb.ticks_left);
    else run = sb.ticks_left + $urandom_range(2);
    if (run > 300) run = 300;
    repeat (run) begin
      if ($urandom_range(5) == 0) send_item(KindGear, pick_gear());
      send_item(KindTick, 4'($urandom_range(15)));
    end
  endtask

  task automatic random_segment(int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) random_episode();
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: short timings, largest adjust step
    write_config(2, 3, 2, 1, 1023, 2, 1);
    send_item(KindSpare, 4'hF);
    send_item(KindTick, 4'h0);          // tick while idle does nothing
    send_item(KindNeutral, 4'h0);       // gear unknown after reset: up pulse
    send_item(KindGear, GearSecond);    // overshoot, up length saturates at zero
    tick_until_idle(1'b0);
    send_item(KindNeutral, 4'h0);       // second gear: down pulse
    send_item(KindGear, GearFirst);
    tick_until_idle(1'b0);
    send_item(KindNeutral, 4'h0);       // zero-length pulse ends on next tick
    tick_until_idle(1'b0);
    send_item(KindDown, 4'h0);          // no shift down from first
    send_item(KindGear, GearFifth);
    send_item(KindUp, 4'h0);            // no shift up from fifth
    send_item(KindNeutral, 4'h0);
    send_item(KindSearch, 4'h0);
    send_item(KindDown, 4'h0);
    send_item(KindLaunch, 4'h0);        // busy, ignored
    tick_until_idle(1'b0);
    send_item(KindGear, 4'd3);
    send_item(KindUp, 4'h0);
    tick_until_idle(1'b0);
    send_item(KindLaunch, 4'h0);
    tick_until_idle(1'b0);
    send_item(KindGear, GearUnknown);
    send_item(KindSearch, 4'h0);        // unknown gear: single pulse instead
    send_item(KindGear, GearSecond);
    tick_until_idle(1'b0);
    send_item(KindGear, GearFirst);
    send_item(KindSearch, 4'h0);
    tick_until_idle(1'b1);
    wait_drained();
    write_config(2, 3, 2, 1, 1023, 0, 1);
    send_item(KindGear, GearFirst);
    send_item(KindSearch, 4'h0);        // zero attempt limit: refused at once
    send_item(KindGear, 4'hF);

    // random part in three idling modes
    wait_drained();
    write_config(1, 2, 1, 2, 7, 31, 3);
    random_segment(400);
    wait_drained();
    write_config(3, 1, 4, 1, 0, 1, 2);
    send_idle_pct = 80;
    recv_idle_pct = 13;
    random_segment(400);
    wait_drained();
    write_config(1, 1, 1, 1, 1, 3, 1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_segment(400);

    // largest register values
    wait_drained();
    write_config(65535, 65535, 65535, 65535, 1023, 31, 65535);
    send_item(KindGear, GearSecond);
    send_item(KindSearch, 4'h0);
    repeat (30) begin
      if ($urandom_range(3) == 0) send_item(KindGear, pick_gear());
      send_item(KindTick, 4'h0);
    end
    send_item(KindLaunch, 4'h0);
    send_item(KindUp, 4'h0);

    s_axis_tvalid <= 1'b0;
    while (sb.due_outputs.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.failures == 0 && sb.due_outputs.size() == 0) begin
      $display("gear_shift_sequencer_tb: clean");
    end else begin
      $display("gear_shift_sequencer_tb: errors");
    end
    $finish;
  end
endmodule
